>>> design/frp_pkg.sv
package frp_pkg;

    localparam int PAYLOAD_DEPTH = 256;
    localparam int PAYLOAD_AW = $clog2(PAYLOAD_DEPTH);
    localparam int BANK_AW = PAYLOAD_AW + 1;

    localparam logic [7:0] SYNC_A = 8'hA5;
    localparam logic [7:0] SYNC_B = 8'h5A;
    localparam logic [7:0] TRAILER = 8'hFF;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    typedef enum logic
    {
        OP_RECEIVE = 1'b0,
        OP_READ = 1'b1
    } opcode_t;

    typedef enum logic [1:0]
    {
        EV_NONE = 2'd0,
        EV_DELIVERED = 2'd1,
        EV_SKIPPED = 2'd2
    } event_t;

    typedef struct packed
    {
        event_t ev;
        logic [7:0] cmd;
        logic [7:0] len;
        logic rd_ok;
    } result_t;

    typedef struct packed
    {
        logic en;
        logic we;
        logic [BANK_AW-1:0] addr;
        logic [7:0] wdata;
    } mem_req_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
            begin
                c = (c >> 1) ^ CRC_POLY;
            end
            else
            begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

>>> design/frp_payload_ram.sv
module frp_payload_ram
(
    input  logic               clk,
    input  frp_pkg::mem_req_t  req,
    output logic [7:0]         rdata
);

    logic [7:0] mem [2**frp_pkg::BANK_AW];

    always_ff @(posedge clk)
    begin
        if (req.en)
        begin
            if (req.we)
            begin
                mem[req.addr] <= req.wdata;
            end
            else
            begin
                rdata <= mem[req.addr];
            end
        end
    end

endmodule

>>> design/frp_parser.sv
module frp_parser
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic                opcode,
    input  logic [7:0]          rx_byte,
    input  logic [7:0]          read_index,
    input  logic                consumer_busy,
    output frp_pkg::result_t    result,
    output frp_pkg::mem_req_t   mem_req
);

    typedef enum logic [2:0]
    {
        PH_HUNT,
        PH_SYNC_B,
        PH_LEN,
        PH_CMD,
        PH_PAYLOAD,
        PH_CRC_HI,
        PH_CRC_LO,
        PH_TRAILER
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [7:0]  len_reg, len_next;
    logic [7:0]  cmd_reg, cmd_next;
    logic [7:0]  count_reg, count_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  crc_hi_reg, crc_hi_next;
    logic        bank_reg, bank_next;
    logic        receiving;
    logic        rd_ok;
    logic        wr_ok;
    logic [7:0]  count_inc;

    assign receiving = accept && (opcode == frp_pkg::OP_RECEIVE);
    assign rd_ok = (opcode == frp_pkg::OP_READ)
        && ({1'b0, read_index} < 9'(frp_pkg::PAYLOAD_DEPTH));
    assign wr_ok = (phase_reg == PH_PAYLOAD)
        && ({1'b0, count_reg} < 9'(frp_pkg::PAYLOAD_DEPTH));
    assign count_inc = count_reg + 8'd1;

    always_comb
    begin
        phase_next = phase_reg;
        len_next = len_reg;
        cmd_next = cmd_reg;
        count_next = count_reg;
        crc_next = crc_reg;
        crc_hi_next = crc_hi_reg;
        bank_next = bank_reg;
        result.ev = frp_pkg::EV_NONE;
        result.cmd = 8'h00;
        result.len = 8'h00;
        result.rd_ok = rd_ok;

        unique case (phase_reg)
            PH_HUNT:
            begin
                if (rx_byte == frp_pkg::SYNC_A)
                begin
                    phase_next = PH_SYNC_B;
                    crc_next = frp_pkg::crc_byte(frp_pkg::CRC_INIT, frp_pkg::SYNC_A);
                end
            end
            PH_SYNC_B:
            begin
                if (rx_byte == frp_pkg::SYNC_B)
                begin
                    phase_next = PH_LEN;
                    crc_next = frp_pkg::crc_byte(crc_reg, rx_byte);
                end
                else if (rx_byte == frp_pkg::SYNC_A)
                begin
                    phase_next = PH_SYNC_B;
                    crc_next = frp_pkg::crc_byte(frp_pkg::CRC_INIT, frp_pkg::SYNC_A);
                end
                else
                begin
                    phase_next = PH_HUNT;
                end
            end
            PH_LEN:
            begin
                len_next = rx_byte;
                crc_next = frp_pkg::crc_byte(crc_reg, rx_byte);
                phase_next = PH_CMD;
            end
            PH_CMD:
            begin
                cmd_next = rx_byte;
                crc_next = frp_pkg::crc_byte(crc_reg, rx_byte);
                count_next = 8'h00;
                phase_next = (len_reg == 8'h00) ? PH_CRC_HI : PH_PAYLOAD;
            end
            PH_PAYLOAD:
            begin
                crc_next = frp_pkg::crc_byte(crc_reg, rx_byte);
                count_next = count_inc;
                if (count_inc >= len_reg)
                begin
                    phase_next = PH_CRC_HI;
                end
            end
            PH_CRC_HI:
            begin
                crc_hi_next = rx_byte;
                phase_next = PH_CRC_LO;
            end
            PH_CRC_LO:
            begin
                if ({crc_hi_reg, rx_byte} == crc_reg)
                begin
                    phase_next = PH_TRAILER;
                end
                else if (rx_byte == frp_pkg::SYNC_A)
                begin
                    phase_next = PH_SYNC_B;
                    crc_next = frp_pkg::crc_byte(frp_pkg::CRC_INIT, frp_pkg::SYNC_A);
                end
                else
                begin
                    phase_next = PH_HUNT;
                end
            end
            PH_TRAILER:
            begin
                if (rx_byte == frp_pkg::TRAILER)
                begin
                    phase_next = PH_HUNT;
                    if (opcode == frp_pkg::OP_RECEIVE)
                    begin
                        result.cmd = cmd_reg;
                        result.len = len_reg;
                        if (consumer_busy)
                        begin
                            result.ev = frp_pkg::EV_SKIPPED;
                        end
                        else
                        begin
                            result.ev = frp_pkg::EV_DELIVERED;
                            bank_next = ~bank_reg;
                        end
                    end
                end
                else if (rx_byte == frp_pkg::SYNC_A)
                begin
                    phase_next = PH_SYNC_B;
                    crc_next = frp_pkg::crc_byte(frp_pkg::CRC_INIT, frp_pkg::SYNC_A);
                end
                else
                begin
                    phase_next = PH_HUNT;
                end
            end
            default:
            begin
                phase_next = PH_HUNT;
            end
        endcase
    end

    always_comb
    begin
        mem_req.wdata = rx_byte;
        if (opcode == frp_pkg::OP_READ)
        begin
            mem_req.en = accept && rd_ok;
            mem_req.we = 1'b0;
            mem_req.addr = {bank_reg, read_index[frp_pkg::PAYLOAD_AW-1:0]};
        end
        else
        begin
            mem_req.en = accept && wr_ok;
            mem_req.we = 1'b1;
            mem_req.addr = {~bank_reg, count_reg[frp_pkg::PAYLOAD_AW-1:0]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            len_reg <= 8'h00;
            cmd_reg <= 8'h00;
            count_reg <= 8'h00;
            crc_reg <= frp_pkg::CRC_INIT;
            crc_hi_reg <= 8'h00;
            bank_reg <= 1'b0;
        end
        else if (receiving)
        begin
            phase_reg <= phase_next;
            len_reg <= len_next;
            cmd_reg <= cmd_next;
            count_reg <= count_next;
            crc_reg <= crc_next;
            crc_hi_reg <= crc_hi_next;
            bank_reg <= bank_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        accept && (opcode == frp_pkg::OP_READ) |=> $stable(phase_reg) && $stable(bank_reg))
        else $error("parser state changed on a read beat");

    assert property (@(posedge clk) disable iff (!rst_n)
        mem_req.en && mem_req.we |-> mem_req.addr[frp_pkg::PAYLOAD_AW] != bank_reg)
        else $error("payload write into the delivered bank");

    assert property (@(posedge clk) disable iff (!rst_n)
        (result.ev != frp_pkg::EV_NONE) && receiving |=> phase_reg == PH_HUNT)
        else $error("parser did not return to hunting after a frame");

endmodule

>>> design/crc_frame_receiver.sv
// An accepted beat's result is registered in the holding stage, then in the output register.
// One beat per cycle unless stalled; the payload RAM is single port, one access per beat.
// With the output stalled, the holding stage takes one more beat and then input ready drops.
// Reset is asynchronous and active low; it clears the parser, bank select and valid flags.
// The payload RAM is not cleared; only indices below the delivered length may be read.
module crc_frame_receiver
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        opcode,
    input  logic [7:0]  rx_byte,
    input  logic [7:0]  read_index,
    input  logic        consumer_busy,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  frame_event,
    output logic [7:0]  frame_command,
    output logic [7:0]  frame_length,
    output logic [7:0]  read_data
);

    frp_pkg::result_t  result;
    frp_pkg::mem_req_t mem_req;
    frp_pkg::result_t  s1_res_reg;
    logic              s1_valid_reg;
    logic              s1_move;
    logic              accept;
    logic [7:0]        ram_rdata;
    logic              out_valid_reg;
    logic [1:0]        out_event_reg;
    logic [7:0]        out_cmd_reg;
    logic [7:0]        out_len_reg;
    logic [7:0]        out_data_reg;

    assign s1_move = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_move;
    assign accept = in_valid && in_ready;

    frp_parser u_parser
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .opcode        (opcode),
        .rx_byte       (rx_byte),
        .read_index    (read_index),
        .consumer_busy (consumer_busy),
        .result        (result),
        .mem_req       (mem_req)
    );

    frp_payload_ram u_ram
    (
        .clk   (clk),
        .req   (mem_req),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_move)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_res_reg <= result;
        end
        if (s1_move)
        begin
            out_event_reg <= s1_res_reg.ev;
            out_cmd_reg <= s1_res_reg.cmd;
            out_len_reg <= s1_res_reg.len;
            out_data_reg <= s1_res_reg.rd_ok ? ram_rdata : 8'h00;
        end
    end

    assign out_valid = out_valid_reg;
    assign frame_event = out_event_reg;
    assign frame_command = out_cmd_reg;
    assign frame_length = out_len_reg;
    assign read_data = out_data_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> s1_valid_reg)
        else $error("accepted beat lost before the holding stage");

    assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_move |=> s1_valid_reg && $stable(s1_res_reg))
        else $error("stalled holding stage changed");

    assert property (@(posedge clk) disable iff (!rst_n)
        s1_move |=> out_valid_reg)
        else $error("result did not reach the output register");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_event_reg != frp_pkg::EV_NONE) |-> out_data_reg == 8'h00)
        else $error("frame report carries read data");

endmodule

>>> test/tb_crc_frame_receiver.sv
`timescale 1ns / 100ps

module tb_crc_frame_receiver;

    localparam int DIR_ROWS = 31;
    localparam int RANDOM_ITEMS = 900;
    localparam int HOLD_OFF_CYCLES = 64;
    localparam int WATCHDOG_LIMIT = 1000;

    typedef enum logic [2:0]
    {
        PH_HUNT,
        PH_SYNC_B,
        PH_LENGTH,
        PH_COMMAND,
        PH_PAYLOAD,
        PH_CRC_HI,
        PH_CRC_LO,
        PH_TRAILER
    } parse_phase_t;

    typedef enum logic [1:0]
    {
        SRC_BYTE,
        SRC_CRC_HI,
        SRC_CRC_LO
    } byte_src_t;

    typedef enum logic [2:0]
    {
        FL_NONE,
        FL_BAD_CRC,
        FL_CRC_A5,
        FL_BAD_TRAILER,
        FL_TRAILER_A5,
        FL_TRUNCATED,
        FL_BAD_SYNC
    } frame_flaw_t;

    typedef struct packed
    {
        frp_pkg::event_t ev;
        logic [7:0] cmd;
        logic [7:0] len;
        logic [7:0] rd;
    } frame_result_t;

    typedef struct packed
    {
        frp_pkg::opcode_t op;
        byte_src_t src;
        logic [7:0] val;
        logic busy;
        logic lit;
        frame_result_t res;
    } step_row_t;

    localparam frame_result_t RES_NONE = '{frp_pkg::EV_NONE, 8'h00, 8'h00, 8'h00};

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic opcode;
    logic [7:0] rx_byte;
    logic [7:0] read_index;
    logic consumer_busy;
    logic out_valid;
    logic out_ready;
    logic [1:0] frame_event;
    logic [7:0] frame_command;
    logic [7:0] frame_length;
    logic [7:0] read_data;

    parse_phase_t m_phase;
    logic [7:0] m_len;
    logic [7:0] m_cmd;
    logic [7:0] m_count;
    logic [15:0] m_crc;
    logic [7:0] m_crc_hi;
    logic m_bank;
    logic [7:0] delivered_len;
    logic [7:0] bank_mem [2][256];
    bit bank_written [2][256];

    frame_result_t result_q [$];
    int err_count;
    int items_sent;
    int out_count;
    int stall_cycles;
    bit no_idle;

    // A beat that only reads a delivered byte carries its index; receive rows carry the byte.
    step_row_t frame_script [DIR_ROWS] = '{
        '{frp_pkg::OP_RECEIVE, SRC_BYTE,   8'h00, 1'b0, 1'b1, RES_NONE},
        '{frp_pkg::OP_RECEIVE, SRC_BYTE,   8'hA5, 1'b1, 1'b1, RES_NONE},
        '{frp_pkg::OP_RECEIVE, SRC_BYTE,   8'hA5, 1'b0, 1'b0, RES_NONE},
        '{frp_pkg::OP_RECEIVE, SRC_BYTE,   8'h5A, 1'b0, 1'b0, RES_NONE},
        '{frp_pkg::OP_RECEIVE, SRC_BYTE,   8'h01, 1'b1, 1'b0, RES_NONE},
        '{frp_pkg::OP_RECEIVE, SRC_BYTE,   8'h81, 1'b0, 1'b0, RES_NONE},
        '{frp_pkg::OP_RECEIVE, SRC_BYTE,   8'h7E, 1'b0, 1'b0, RES_NONE},
        '{frp_pkg::OP_RECEIVE, SRC_CRC_HI, 8'h00, 1'b1, 1'b0, RES_NONE},
        '{frp_pkg::OP_RECEIVE, SRC_CRC_LO, 8'h00, 1'b0, 1'b0, RES_NONE},
        '{frp_pkg::OP_RECEIVE, SRC_BYTE,   8'hFF, 1'b0, 1'b1,
            '{frp_pkg::EV_DELIVERED, 8'h81, 8'h01, 8'h00}},
        '{frp_pkg::OP_READ,    SRC_BYTE,   8'h00, 1'b1, 1'b1,
            '{frp_pkg::EV_NONE, 8'h00, 8'h00, 8'h7E}},
        '{frp_pkg::OP_RECEIVE, SRC_BYTE,   8'hA5, 1'b0, 1'b0, RES_NONE},
        '{frp_pkg::OP_RECEIVE, SRC_BYTE,   8'h5A, 1'b0, 1'b0, RES_NONE},
        '{frp_pkg::OP_RECEIVE, SRC_BYTE,   8'h00, 1'b0, 1'b0, RES_NONE},
        '{frp_pkg::OP_RECEIVE, SRC_BYTE,   8'hFF, 1'b0, 1'b0, RES_NONE},
        '{frp_pkg::OP_RECEIVE, SRC_CRC_HI, 8'h00, 1'b0, 1'b0, RES_NONE},
        '{frp_pkg::OP_RECEIVE, SRC_BYTE,   8'hA5, 1'b0, 1'b0, RES_NONE},
        '{frp_pkg::OP_RECEIVE, SRC_BYTE,   8'h5A, 1'b0, 1'b0, RES_NONE},
        '{frp_pkg::OP_RECEIVE, SRC_BYTE,   8'h00, 1'b0, 1'b0, RES_NONE},
        '{frp_pkg::OP_RECEIVE, SRC_BYTE,   8'hFF, 1'b0, 1'b0, RES_NONE},
        '{frp_pkg::OP_RECEIVE, SRC_CRC_HI, 8'h00, 1'b0, 1'b0, RES_NONE},
        '{frp_pkg::OP_RECEIVE, SRC_CRC_LO, 8'h00, 1'b0, 1'b0, RES_NONE},
        '{frp_pkg::OP_RECEIVE, SRC_BYTE,   8'hA5, 1'b0, 1'b0, RES_NONE},
        '{frp_pkg::OP_RECEIVE, SRC_BYTE,   8'h13, 1'b0, 1'b0, RES_NONE},
        '{frp_pkg::OP_RECEIVE, SRC_BYTE,   8'hA5, 1'b0, 1'b0, RES_NONE},
        '{frp_pkg::OP_RECEIVE, SRC_BYTE,   8'h5A, 1'b0, 1'b0, RES_NONE},
        '{frp_pkg::OP_RECEIVE, SRC_BYTE,   8'h00, 1'b0, 1'b0, RES_NONE},
        '{frp_pkg::OP_RECEIVE, SRC_BYTE,   8'h00, 1'b0, 1'b0, RES_NONE},
        '{frp_pkg::OP_RECEIVE, SRC_CRC_HI, 8'h00, 1'b0, 1'b0, RES_NONE},
        '{frp_pkg::OP_RECEIVE, SRC_CRC_LO, 8'h00, 1'b0, 1'b0, RES_NONE},
        '{frp_pkg::OP_RECEIVE, SRC_BYTE,   8'hFF, 1'b1, 1'b1,
            '{frp_pkg::EV_SKIPPED, 8'h00, 8'h00, 8'h00}}
    };

    crc_frame_receiver dut
    (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .opcode(opcode),
        .rx_byte(rx_byte),
        .read_index(read_index),
        .consumer_busy(consumer_busy),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .frame_event(frame_event),
        .frame_command(frame_command),
        .frame_length(frame_length),
        .read_data(read_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [15:0] crc16_update(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        logic fb;
        c = crc_in;
        for (int i = 0; i < 8; i++)
        begin
            fb = c[0] ^ b[i];
            c = c >> 1;
            if (fb)
            begin
                c = c ^ frp_pkg::CRC_POLY;
            end
        end
        return c;
    endfunction

    task automatic predict_beat(input frp_pkg::opcode_t op, input logic [7:0] b,
                                input logic [7:0] idx, input logic busy,
                                output frame_result_t r);
        r = RES_NONE;
        if (op == frp_pkg::OP_READ)
        begin
            r.rd = bank_mem[m_bank][idx];
        end
        else
        begin
            case (m_phase)
                PH_HUNT:
                begin
                    if (b == frp_pkg::SYNC_A)
                    begin
                        m_phase = PH_SYNC_B;
                        m_crc = crc16_update(frp_pkg::CRC_INIT, frp_pkg::SYNC_A);
                    end
                end
                PH_SYNC_B:
                begin
                    if (b == frp_pkg::SYNC_B)
                    begin
                        m_crc = crc16_update(m_crc, b);
                        m_phase = PH_LENGTH;
                    end
                    else if (b == frp_pkg::SYNC_A)
                    begin
                        m_phase = PH_SYNC_B;
                        m_crc = crc16_update(frp_pkg::CRC_INIT, frp_pkg::SYNC_A);
                    end
                    else
                    begin
                        m_phase = PH_HUNT;
                    end
                end
                PH_LENGTH:
                begin
                    m_len = b;
                    m_crc = crc16_update(m_crc, b);
                    m_phase = PH_COMMAND;
                end
                PH_COMMAND:
                begin
                    m_cmd = b;
                    m_crc = crc16_update(m_crc, b);
                    m_count = 8'd0;
                    m_phase = (m_len == 8'd0) ? PH_CRC_HI : PH_PAYLOAD;
                end
                PH_PAYLOAD:
                begin
                    bank_mem[~m_bank][m_count] = b;
                    bank_written[~m_bank][m_count] = 1'b1;
                    m_crc = crc16_update(m_crc, b);
                    m_count = m_count + 8'd1;
                    if (m_count >= m_len)
                    begin
                        m_phase = PH_CRC_HI;
                    end
                end
                PH_CRC_HI:
                begin
                    m_crc_hi = b;
                    m_phase = PH_CRC_LO;
                end
                PH_CRC_LO:
                begin
                    if ({m_crc_hi, b} == m_crc)
                    begin
                        m_phase = PH_TRAILER;
                    end
                    else if (b == frp_pkg::SYNC_A)
                    begin
                        m_phase = PH_SYNC_B;
                        m_crc = crc16_update(frp_pkg::CRC_INIT, frp_pkg::SYNC_A);
                    end
                    else
                    begin
                        m_phase = PH_HUNT;
                    end
                end
                default:
                begin
                    if (b == frp_pkg::TRAILER)
                    begin
                        r.cmd = m_cmd;
                        r.len = m_len;
                        if (!busy)
                        begin
                            m_bank = ~m_bank;
                            delivered_len = m_len;
                            r.ev = frp_pkg::EV_DELIVERED;
                        end
                        else
                        begin
                            r.ev = frp_pkg::EV_SKIPPED;
                        end
                        m_phase = PH_HUNT;
                    end
                    else if (b == frp_pkg::SYNC_A)
                    begin
                        m_phase = PH_SYNC_B;
                        m_crc = crc16_update(frp_pkg::CRC_INIT, frp_pkg::SYNC_A);
                    end
                    else
                    begin
                        m_phase = PH_HUNT;
                    end
                end
            endcase
        end
    endtask

    task automatic drive_beat(input frp_pkg::opcode_t op, input logic [7:0] b,
                              input logic [7:0] idx, input logic busy,
                              input logic use_lit, input frame_result_t lit);
        frame_result_t want;
        @(negedge clk);
        while (!no_idle && $urandom_range(0, 99) < 27)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        opcode <= op;
        rx_byte <= b;
        read_index <= idx;
        consumer_busy <= busy;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        predict_beat(op, b, idx, busy, want);
        result_q.push_back(use_lit ? lit : want);
        items_sent++;
    endtask

    task automatic rx(input logic [7:0] b);
        drive_beat(frp_pkg::OP_RECEIVE, b, 8'($urandom), $urandom_range(0, 99) < 35,
                   1'b0, RES_NONE);
    endtask

    task automatic read_burst(input int unsigned n);
        logic [7:0] idx;
        for (int i = 0; i < n; i++)
        begin
            idx = 8'($urandom);
            if (!bank_written[m_bank][idx])
            begin
                if (delivered_len == 8'd0)
                begin
                    return;
                end
                idx = 8'($urandom_range(0, delivered_len - 1));
            end
            drive_beat(frp_pkg::OP_READ, 8'($urandom), idx, $urandom_range(0, 1),
                       1'b0, RES_NONE);
        end
    endtask

    task automatic send_frame(input int unsigned len, input frame_flaw_t flaw,
                              input logic trailer_busy);
        logic [7:0] lo;
        logic [7:0] tail;
        int unsigned cut;
        if ($urandom_range(0, 9) == 0)
        begin
            rx(frp_pkg::SYNC_A);
        end
        rx(frp_pkg::SYNC_A);
        if (flaw == FL_BAD_SYNC)
        begin
            rx(8'($urandom));
            return;
        end
        rx(frp_pkg::SYNC_B);
        rx(8'(len));
        rx(8'($urandom));
        cut = (len == 0) ? 0 : $urandom_range(0, len - 1);
        for (int unsigned k = 0; k < len; k++)
        begin
            if (flaw == FL_TRUNCATED && k == cut)
            begin
                return;
            end
            rx(8'($urandom));
        end
        rx(m_crc[15:8]);
        lo = m_crc[7:0];
        if (flaw == FL_BAD_CRC)
        begin
            lo = lo ^ 8'($urandom_range(1, 255));
        end
        else if (flaw == FL_CRC_A5 && lo != frp_pkg::SYNC_A)
        begin
            lo = frp_pkg::SYNC_A;
        end
        rx(lo);
        tail = frp_pkg::TRAILER;
        if (flaw == FL_BAD_TRAILER)
        begin
            tail = 8'($urandom_range(0, 254));
        end
        else if (flaw == FL_TRAILER_A5)
        begin
            tail = frp_pkg::SYNC_A;
        end
        drive_beat(frp_pkg::OP_RECEIVE, tail, 8'($urandom), trailer_busy, 1'b0, RES_NONE);
    endtask

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("%0t: mismatch on %s: got %h, expected %h", $time, what, got, want);
        err_count++;
    endtask

    always @(posedge clk)
    begin
        frame_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            out_count++;
            if (result_q.size() == 0)
            begin
                report_mismatch("result with nothing pending", {6'd0, frame_event}, 8'h00);
            end
            else
            begin
                want = result_q.pop_front();
                if (frame_event !== want.ev)
                begin
                    report_mismatch("frame_event", {6'd0, frame_event}, {6'd0, want.ev});
                end
                if (frame_command !== want.cmd)
                begin
                    report_mismatch("frame_command", frame_command, want.cmd);
                end
                if (frame_length !== want.len)
                begin
                    report_mismatch("frame_length", frame_length, want.len);
                end
                if (read_data !== want.rd)
                begin
                    report_mismatch("read_data", read_data, want.rd);
                end
            end
        end
    end

    initial
    begin
        bit held;
        held = 1'b0;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!held && out_count >= 200)
            begin
                held = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
            end
            out_ready <= no_idle || ($urandom_range(0, 99) >= 27);
        end
    end

    initial
    begin
        stall_cycles = 0;
        while (stall_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
            begin
                stall_cycles = 0;
            end
            else
            begin
                stall_cycles++;
            end
        end
        $display("FAIL");
        $finish;
    end

    initial
    begin
        step_row_t row;
        logic [7:0] b;
        int unsigned pick;
        int unsigned len;
        frame_flaw_t flaw;

        rst_n = 1'b0;
        in_valid = 1'b0;
        opcode = frp_pkg::OP_RECEIVE;
        rx_byte = 8'h00;
        read_index = 8'h00;
        consumer_busy = 1'b0;
        err_count = 0;
        items_sent = 0;
        out_count = 0;
        no_idle = 1'b0;

        m_phase = PH_HUNT;
        m_len = 8'd0;
        m_cmd = 8'd0;
        m_count = 8'd0;
        m_crc = frp_pkg::CRC_INIT;
        m_crc_hi = 8'd0;
        m_bank = 1'b0;
        delivered_len = 8'd0;
        for (int i = 0; i < 256; i++)
        begin
            bank_written[0][i] = 1'b0;
            bank_written[1][i] = 1'b0;
            bank_mem[0][i] = 8'h00;
            bank_mem[1][i] = 8'h00;
        end

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (frame_script[i])
        begin
            row = frame_script[i];
            case (row.src)
                SRC_CRC_HI: b = m_crc[15:8];
                SRC_CRC_LO: b = m_crc[7:0];
                default: b = row.val;
            endcase
            if (row.op == frp_pkg::OP_READ)
            begin
                drive_beat(frp_pkg::OP_READ, 8'($urandom), row.val, row.busy, row.lit,
                           row.res);
            end
            else
            begin
                drive_beat(frp_pkg::OP_RECEIVE, b, 8'($urandom), row.busy, row.lit,
                           row.res);
            end
        end

        // A long frame delivered early lets reads reach the upper half of the bank.
        send_frame($urandom_range(128, 255), FL_NONE, 1'b0);
        read_burst(8);

        while (items_sent < DIR_ROWS + RANDOM_ITEMS)
        begin
            no_idle = (items_sent >= 450 && items_sent < 600);
            pick = $urandom_range(0, 99);
            if (pick < 75)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 70)
                begin
                    len = $urandom_range(0, 6);
                end
                else if (pick < 96)
                begin
                    len = $urandom_range(7, 40);
                end
                else
                begin
                    len = $urandom_range(41, 255);
                end
                flaw = FL_NONE;
                if ($urandom_range(0, 99) < 30)
                begin
                    flaw = frame_flaw_t'($urandom_range(1, 6));
                end
                send_frame(len, flaw, $urandom_range(0, 99) < 35);
            end
            else if (pick < 90)
            begin
                read_burst($urandom_range(1, 6));
            end
            else
            begin
                repeat ($urandom_range(1, 4)) rx(8'($urandom));
            end
        end
        no_idle = 1'b0;

        @(negedge clk);
        in_valid <= 1'b0;
        while (result_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);

        if (err_count == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
